// ===== design/cwc_pkg.sv =====
// cwc_pkg: types, field widths, reset values and codes for the congestion window controller
// depends on nothing; cwc_ctrl, cwc_datapath and congestion_window_controller import it
package cwc_pkg;

  localparam int unsigned WINDOW_BITS_DEFAULT = 32;

  localparam int unsigned MTU_BITS     = 14;
  localparam int unsigned THRESH_BITS  = 32;
  localparam int unsigned BASE_BITS    = 20;
  localparam int unsigned RTT_BITS     = 24;
  localparam int unsigned RETRY_BITS   = 4;
  localparam int unsigned FLIGHT_BITS  = 32;
  localparam int unsigned TMO_BITS     = 32;
  localparam int unsigned CFG_ADDR_BITS = 2;
  localparam int unsigned CFG_DATA_BITS = 32;

  // width of mtu squared, the dividend of the avoidance step
  localparam int unsigned SQ_BITS = 2 * MTU_BITS;
  // 2*avg + 4*var + base always fits here
  localparam int unsigned TMO_SUM_BITS = RTT_BITS + 3;
  localparam int unsigned TMO_MULT_BITS = RETRY_BITS + 1;

  // one quotient bit per divider step
  localparam int unsigned DIV_STEPS = SQ_BITS;
  localparam int unsigned DIV_CNT_BITS = $clog2(DIV_STEPS);

  localparam logic [MTU_BITS-1:0]    MTU_RESET    = MTU_BITS'(1400);
  localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(65536);
  localparam logic [BASE_BITS-1:0]   BASE_RESET   = BASE_BITS'(1000);
  localparam logic [THRESH_BITS-1:0] U32_MAX      = '1;

  // timeout for a connection with no round-trip history: 100 ms
  localparam logic [TMO_SUM_BITS-1:0] NO_HISTORY_US = TMO_SUM_BITS'(100000);

  // command codes; the unused code behaves as a query
  localparam logic [1:0] CMD_QUERY = 2'd0;
  localparam logic [1:0] CMD_ACK   = 2'd1;
  localparam logic [1:0] CMD_NAK   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_ADDR_BITS-1:0] CFG_MTU    = CFG_ADDR_BITS'(0);
  localparam logic [CFG_ADDR_BITS-1:0] CFG_THRESH = CFG_ADDR_BITS'(1);
  localparam logic [CFG_ADDR_BITS-1:0] CFG_BASE   = CFG_ADDR_BITS'(2);

  typedef struct packed {
    logic [1:0]             command;
    logic [FLIGHT_BITS-1:0] bytes_in_flight;
    logic [RTT_BITS-1:0]    rtt_average_us;
    logic [RTT_BITS-1:0]    rtt_minimum_us;
    logic [RTT_BITS-1:0]    rtt_maximum_us;
    logic                   rtt_history_valid;
    logic [RETRY_BITS-1:0]  retry_count;
  } cwc_item_t;

  typedef struct packed {
    logic [THRESH_BITS-1:0] window_bytes;
    logic [THRESH_BITS-1:0] threshold_bytes;
    logic                   in_slow_start;
    logic [MTU_BITS-1:0]    transmit_budget;
    logic [MTU_BITS-1:0]    retransmit_budget;
    logic [TMO_BITS-1:0]    timeout_us;
  } cwc_result_t;

  typedef struct packed {
    logic [CFG_ADDR_BITS-1:0] addr;
    logic [CFG_DATA_BITS-1:0] value;
  } cwc_cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_DIVIDE,
    S_GROW,
    S_CALC,
    S_FINISH
  } cwc_state_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic ss_add;
    logic nak;
    logic div_init;
    logic div_step;
    logic grow;
    logic calc;
    logic load_out;
  } cwc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_ack;
    logic is_nak;
    logic slow;
  } cwc_status_t;

endpackage

// ===== design/cwc_chan_if.sv =====
// cwc_chan_if: valid/ready channel carrying one payload per transfer
// payload type is set per instance, usually a struct from cwc_pkg
interface cwc_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/cwc_ctrl.sv =====
// cwc_ctrl: sequencer for the congestion window controller
// depends on cwc_pkg; drives the command struct of cwc_datapath
module cwc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  cwc_pkg::cwc_status_t status,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                out_ready,
  output logic                out_valid,
  output cwc_pkg::cwc_cmd_t   cmd
);
  import cwc_pkg::*;

  cwc_state_t              state, state_next;
  logic [DIV_CNT_BITS-1:0] count;
  logic                    out_free;

  assign out_free = !out_valid || out_ready;
  // no transfer is taken while reset is held
  assign in_ready = (state == S_IDLE) && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.div_init) begin
        count <= '0;
      end else if (cmd.div_step) begin
        count <= count + 1'b1;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_UPDATE;
      end
      S_UPDATE: begin
        if (status.is_ack && !status.slow) state_next = S_DIVIDE;
        else                               state_next = S_CALC;
      end
      S_DIVIDE: begin
        if (count == DIV_CNT_BITS'(DIV_STEPS - 1)) state_next = S_GROW;
      end
      S_GROW:   state_next = S_CALC;
      S_CALC:   state_next = S_FINISH;
      S_FINISH: begin
        if (out_free) state_next = S_IDLE;
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE:   cmd.load_item = in_valid;
      S_UPDATE: begin
        cmd.ss_add   = status.is_ack && status.slow;
        cmd.div_init = status.is_ack && !status.slow;
        cmd.nak      = status.is_nak;
      end
      S_DIVIDE: cmd.div_step = 1'b1;
      S_GROW:   cmd.grow = 1'b1;
      S_CALC:   cmd.calc = 1'b1;
      S_FINISH: cmd.load_out = out_free;
      default:  cmd = '0;
    endcase
  end

endmodule

// ===== design/cwc_datapath.sv =====
// cwc_datapath: window and threshold state, config registers, serial divider,
// budget and timeout arithmetic and the result register; depends on cwc_pkg
module cwc_datapath #(
  parameter int unsigned WINDOW_BITS = cwc_pkg::WINDOW_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cwc_pkg::cwc_cmd_t    cmd,
  output cwc_pkg::cwc_status_t status,
  input  cwc_pkg::cwc_item_t   item_data,
  input  logic                 cfg_write,
  input  cwc_pkg::cwc_cfg_t    cfg_data,
  output cwc_pkg::cwc_result_t result_data
);
  import cwc_pkg::*;

  localparam int unsigned W     = WINDOW_BITS;
  localparam int unsigned CMP_W = (W > THRESH_BITS) ? W : THRESH_BITS;
  localparam int unsigned SUM_W = ((W > SQ_BITS) ? W : SQ_BITS) + 2;

  // configuration
  logic [MTU_BITS-1:0]  mtu;
  logic [BASE_BITS-1:0] base;

  // state
  logic [W-1:0]           window;
  logic [THRESH_BITS-1:0] threshold;

  // captured item
  cwc_item_t item_r;

  // divider
  logic [W-1:0]       rem;
  logic [SQ_BITS-1:0] quo;
  logic [W:0]         rem_sh;
  logic [W:0]         rem_diff;
  logic               fits;

  // arithmetic
  logic [W:0]             ss_sum;
  logic [W-1:0]           ss_win;
  logic [W-1:0]           half;
  logic [W-1:0]           floor2;
  logic [W-1:0]           nak_t;
  logic [CMP_W-1:0]       nak_ext;
  logic [THRESH_BITS-1:0] thr_next;
  logic [SUM_W-1:0]       grow_sum;
  logic [W-1:0]           grow_win;
  logic [CMP_W-1:0]       win_ext;
  logic [CMP_W-1:0]       flight_ext;
  logic                   slow;

  // calc stage
  logic [MTU_BITS-1:0]      rtx, rtx_r, room_r;
  logic [CMP_W-1:0]         avail, avail_r;
  logic [RTT_BITS-1:0]      rtt_var;
  logic [TMO_SUM_BITS-1:0]  tmo_sum, tmo_sum_r;
  logic [TMO_MULT_BITS-1:0] tmo_mult, tmo_mult_r;
  logic [THRESH_BITS-1:0]   win_out_r;
  logic                     slow_r;
  logic [MTU_BITS-1:0]      tx;
  logic [TMO_BITS-1:0]      tmo;

  always_ff @(posedge clk) begin
    if (rst) begin
      mtu  <= MTU_RESET;
      base <= BASE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_data.addr)
        CFG_MTU:    mtu  <= cfg_data.value[MTU_BITS-1:0];
        CFG_BASE:   base <= cfg_data.value[BASE_BITS-1:0];
        // the threshold takes its starting value only at reset
        CFG_THRESH: ;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) item_r <= item_data;
  end

  assign status.is_ack = (item_r.command == CMD_ACK);
  assign status.is_nak = (item_r.command == CMD_NAK);
  assign status.slow   = slow;

  assign win_ext    = CMP_W'(window);
  assign flight_ext = CMP_W'(item_r.bytes_in_flight);
  assign slow       = win_ext <= CMP_W'(threshold);

  // slow start step
  assign ss_sum = {1'b0, window} + (W+1)'(mtu);
  assign ss_win = ss_sum[W] ? '1 : ss_sum[W-1:0];

  // loss: threshold to max(window/2, 2*mtu), clipped to 32 bits
  assign half     = window >> 1;
  assign floor2   = W'({mtu, 1'b0});
  assign nak_t    = (half > floor2) ? half : floor2;
  assign nak_ext  = CMP_W'(nak_t);
  assign thr_next = (nak_ext > CMP_W'(U32_MAX)) ? U32_MAX : nak_ext[THRESH_BITS-1:0];

  // restoring division of mtu*mtu by the window, one quotient bit a cycle;
  // window is non-zero here as it exceeds the threshold
  assign rem_sh   = {rem, quo[SQ_BITS-1]};
  assign fits     = rem_sh >= {1'b0, window};
  assign rem_diff = rem_sh - {1'b0, window};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem <= '0;
      quo <= SQ_BITS'(mtu) * SQ_BITS'(mtu);
    end else if (cmd.div_step) begin
      rem <= fits ? rem_diff[W-1:0] : rem_sh[W-1:0];
      quo <= {quo[SQ_BITS-2:0], fits};
    end
  end

  // avoidance step: window + mtu*mtu/window + mtu/8, saturating
  assign grow_sum = SUM_W'(window) + SUM_W'(quo) + SUM_W'(mtu >> 3);
  assign grow_win = (grow_sum > SUM_W'({W{1'b1}})) ? '1 : grow_sum[W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      window    <= W'(MTU_RESET);
      threshold <= THRESH_RESET;
    end else begin
      if (cmd.ss_add) window <= ss_win;
      if (cmd.grow)   window <= grow_win;
      if (cmd.nak) begin
        window    <= W'(mtu);
        threshold <= thr_next;
      end
    end
  end

  // budgets and timeout operands
  assign rtx   = (item_r.bytes_in_flight < FLIGHT_BITS'(mtu)) ?
                 item_r.bytes_in_flight[MTU_BITS-1:0] : mtu;
  assign avail = (flight_ext >= win_ext) ? '0 : win_ext - flight_ext;

  assign rtt_var = (item_r.rtt_maximum_us > item_r.rtt_minimum_us) ?
                   item_r.rtt_maximum_us - item_r.rtt_minimum_us : '0;

  always_comb begin
    if (item_r.rtt_history_valid) begin
      tmo_sum  = (TMO_SUM_BITS'(item_r.rtt_average_us) << 1)
               + (TMO_SUM_BITS'(rtt_var) << 2)
               + TMO_SUM_BITS'(base);
      tmo_mult = TMO_MULT_BITS'(item_r.retry_count) + 1'b1;
    end else begin
      tmo_sum  = NO_HISTORY_US + TMO_SUM_BITS'(base);
      tmo_mult = TMO_MULT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      rtx_r      <= rtx;
      room_r     <= mtu - rtx;
      avail_r    <= avail;
      tmo_sum_r  <= tmo_sum;
      tmo_mult_r <= tmo_mult;
      slow_r     <= slow;
      win_out_r  <= (win_ext > CMP_W'(U32_MAX)) ? U32_MAX : win_ext[THRESH_BITS-1:0];
    end
  end

  assign tx  = (avail_r < CMP_W'(room_r)) ? avail_r[MTU_BITS-1:0] : room_r;
  // the product stays below 2^32 for every operand value
  assign tmo = TMO_BITS'(tmo_sum_r) * TMO_BITS'(tmo_mult_r);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      result_data.window_bytes      <= win_out_r;
      result_data.threshold_bytes   <= threshold;
      result_data.in_slow_start     <= slow_r;
      result_data.transmit_budget   <= tx;
      result_data.retransmit_budget <= rtx_r;
      result_data.timeout_us        <= tmo;
    end
  end

endmodule

// ===== design/congestion_window_controller.sv =====
// channel   dir  payload              handshake
// item      in   cwc_pkg::cwc_item_t  valid/ready, transfer on both high
// result    out  cwc_pkg::cwc_result_t valid/ready, one result per item
// cfg       in   cwc_pkg::cwc_cfg_t   valid/ready, ready high outside reset
//
// an ack in congestion avoidance runs the 28-step restoring divider (mtu*mtu/window)
// between its transfer and the next item being taken; every other item skips it.
// one item is in work at a time.
// rst is synchronous: window loads 1400, threshold 65536, registers their defaults.
// a stalled result sits in the output register while the next item is taken.
// depends on cwc_pkg, cwc_chan_if, cwc_ctrl and cwc_datapath
module congestion_window_controller #(
  parameter int unsigned WINDOW_BITS = cwc_pkg::WINDOW_BITS_DEFAULT
) (
  input logic     clk,
  input logic     rst,
  cwc_chan_if.sink   item,
  cwc_chan_if.source result,
  cwc_chan_if.sink   cfg
);
  import cwc_pkg::*;

  cwc_cmd_t    cmd;
  cwc_status_t status;

  assign cfg.ready = !rst;

  cwc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .status    (status),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_ready (result.ready),
    .out_valid (result.valid),
    .cmd       (cmd)
  );

  cwc_datapath #(
    .WINDOW_BITS (WINDOW_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .item_data   (item.data),
    .cfg_write   (cfg.valid),
    .cfg_data    (cfg.data),
    .result_data (result.data)
  );

endmodule

// ===== tb/tb_congestion_window_controller.sv =====
// testbench for congestion_window_controller: directed and random items checked
// against a local prediction of the window, threshold, budgets and timeout
// depends on cwc_pkg, cwc_chan_if and the design files
`timescale 1ns / 100ps

module tb_congestion_window_controller;
  import cwc_pkg::*;

  localparam int unsigned WIN_BITS = WINDOW_BITS_DEFAULT;
  localparam bit [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam bit [63:0] WIN_LIMIT = ALL_ONES >> (64 - WIN_BITS);
  localparam bit [63:0] U32_LIMIT = 64'h0000_0000_FFFF_FFFF;
  // unused command code, handled as a query
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int unsigned RANDOM_PER_PHASE = 125;
  localparam int unsigned DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cwc_chan_if #(.payload_t(cwc_item_t))   item_ch ();
  cwc_chan_if #(.payload_t(cwc_result_t)) result_ch ();
  cwc_chan_if #(.payload_t(cwc_cfg_t))    cfg_ch ();

  congestion_window_controller dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always #6 clk = ~clk;

  cwc_item_t   pending_items[$];
  cwc_cfg_t    reg_writes[$];
  cwc_result_t expected_results[$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned mismatches;

  // predicted block state and register copies
  bit [63:0]          cong_window;
  bit [63:0]          slow_threshold;
  bit [MTU_BITS-1:0]  mtu_reg;
  bit [THRESH_BITS-1:0] init_thresh_reg;
  bit [BASE_BITS-1:0] base_reg;

  function automatic bit [63:0] add_clamped(bit [63:0] a, bit [63:0] b, bit [63:0] lim);
    if (a > lim || b > lim - a) return lim;
    return a + b;
  endfunction

  function automatic cwc_result_t advance_window(cwc_item_t it);
    bit [63:0] mtu;
    bit [63:0] quot;
    bit [63:0] halfwin;
    bit [63:0] spread;
    bit [63:0] rtx;
    bit [63:0] avail;
    bit [63:0] tx;
    bit [63:0] tmo;
    cwc_result_t r;
    mtu = 64'(mtu_reg);
    case (it.command)
      CMD_ACK: begin
        if (cong_window <= slow_threshold) begin
          cong_window = add_clamped(cong_window, mtu, WIN_LIMIT);
        end else begin
          quot = (cong_window == 0) ? ALL_ONES : (mtu * mtu) / cong_window;
          cong_window = add_clamped(cong_window, add_clamped(quot, mtu >> 3, ALL_ONES),
                                    WIN_LIMIT);
        end
      end
      CMD_NAK: begin
        halfwin = cong_window >> 1;
        if (halfwin < (mtu << 1)) halfwin = mtu << 1;
        slow_threshold = (halfwin > U32_LIMIT) ? U32_LIMIT : halfwin;
        cong_window = mtu & WIN_LIMIT;
      end
      default: ;
    endcase

    rtx = (64'(it.bytes_in_flight) < mtu) ? 64'(it.bytes_in_flight) : mtu;
    avail = (64'(it.bytes_in_flight) >= cong_window) ? 64'd0
                                                      : cong_window - it.bytes_in_flight;
    tx = (avail < mtu - rtx) ? avail : mtu - rtx;

    if (!it.rtt_history_valid) begin
      tmo = 64'(NO_HISTORY_US) + 64'(base_reg);
    end else begin
      spread = (it.rtt_maximum_us > it.rtt_minimum_us)
               ? 64'(it.rtt_maximum_us) - 64'(it.rtt_minimum_us) : 64'd0;
      tmo = ((64'(it.rtt_average_us) << 1) + (spread << 2) + 64'(base_reg))
            * (64'(it.retry_count) + 64'd1);
    end
    if (tmo > U32_LIMIT) tmo = U32_LIMIT;

    r.window_bytes      = (cong_window > U32_LIMIT) ? '1 : cong_window[31:0];
    r.threshold_bytes   = slow_threshold[31:0];
    r.in_slow_start     = (cong_window <= slow_threshold);
    r.transmit_budget   = tx[MTU_BITS-1:0];
    r.retransmit_budget = rtx[MTU_BITS-1:0];
    r.timeout_us        = tmo[31:0];
    return r;
  endfunction

  // item driver: valid held until the transfer, prediction taken on acceptance
  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid  <= 1'b0;
      cong_window    = 64'(MTU_RESET) & WIN_LIMIT;
      slow_threshold = 64'(THRESH_RESET);
    end else begin
      if (item_ch.valid && item_ch.ready)
        expected_results.push_back(advance_window(item_ch.data));
      if (!item_ch.valid || item_ch.ready) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          item_ch.valid <= 1'b1;
          item_ch.data  <= pending_items.pop_front();
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // register write driver
  always @(posedge clk) begin
    if (rst) begin
      cfg_ch.valid    <= 1'b0;
      mtu_reg         = MTU_RESET;
      init_thresh_reg = THRESH_RESET;
      base_reg        = BASE_RESET;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.data.addr)
          CFG_MTU:    mtu_reg = cfg_ch.data.value[MTU_BITS-1:0];
          CFG_THRESH: init_thresh_reg = cfg_ch.data.value[THRESH_BITS-1:0];
          CFG_BASE:   base_reg = cfg_ch.data.value[BASE_BITS-1:0];
          default: ;
        endcase
      end
      if (!cfg_ch.valid || cfg_ch.ready) begin
        if (reg_writes.size() > 0) begin
          cfg_ch.valid <= 1'b1;
          cfg_ch.data  <= reg_writes.pop_front();
        end else begin
          cfg_ch.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %0h, got %0h", name, want, got);
    end
  endtask

  // result monitor
  always @(posedge clk) begin : result_monitor
    cwc_result_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result transfer with nothing outstanding: %p", result_ch.data);
        end else begin
          want = expected_results.pop_front();
          check_field("window_bytes", want.window_bytes, result_ch.data.window_bytes);
          check_field("threshold_bytes", want.threshold_bytes,
                      result_ch.data.threshold_bytes);
          check_field("in_slow_start", want.in_slow_start, result_ch.data.in_slow_start);
          check_field("transmit_budget", want.transmit_budget,
                      result_ch.data.transmit_budget);
          check_field("retransmit_budget", want.retransmit_budget,
                      result_ch.data.retransmit_budget);
          check_field("timeout_us", want.timeout_us, result_ch.data.timeout_us);
        end
      end
      result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic queue_item(logic [1:0] cmd, logic [31:0] inflight, logic [23:0] avg,
                            logic [23:0] mn, logic [23:0] mx, logic hist,
                            logic [3:0] retries);
    cwc_item_t it;
    it.command           = cmd;
    it.bytes_in_flight   = inflight;
    it.rtt_average_us    = avg;
    it.rtt_minimum_us    = mn;
    it.rtt_maximum_us    = mx;
    it.rtt_history_valid = hist;
    it.retry_count       = retries;
    pending_items.push_back(it);
  endtask

  task automatic write_reg(logic [CFG_ADDR_BITS-1:0] addr, logic [CFG_DATA_BITS-1:0] value);
    cwc_cfg_t w;
    w.addr  = addr;
    w.value = value;
    reg_writes.push_back(w);
  endtask

  // sampled on the falling edge so the drivers' updates have settled
  task automatic wait_drained();
    @(negedge clk);
    while (pending_items.size() > 0 || item_ch.valid || reg_writes.size() > 0 ||
           cfg_ch.valid || expected_results.size() > 0)
      @(negedge clk);
  endtask

  function automatic logic [23:0] rtt_sample();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return 24'($urandom_range(0, 5000));
      default: return 24'($urandom);
    endcase
  endfunction

  initial begin
    logic [1:0]  cmd;
    logic [31:0] inflight;
    int unsigned pick;
    int unsigned failures;

    item_ch.valid   = 1'b0;
    item_ch.data    = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.data     = '0;
    result_ch.ready = 1'b0;
    mismatches      = 0;
    send_idle_pct   = 25;
    recv_idle_pct   = 68;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset defaults: every command, field extremes, into avoidance and back
    queue_item(CMD_QUERY, 32'd0, 24'd0, 24'd0, 24'd0, 1'b0, 4'd0);
    queue_item(CMD_QUERY, '1, '1, 24'd0, '1, 1'b1, 4'hF);
    queue_item(CMD_ACK, 32'd0, 24'd100, 24'd50, 24'd200, 1'b1, 4'd1);
    // max rtt below min rtt gives no variance
    queue_item(CMD_SPARE, 32'd700, 24'd300, '1, 24'd0, 1'b1, 4'd2);
    queue_item(CMD_NAK, 32'd1400, 24'd10, 24'd5, 24'd20, 1'b1, 4'd0);
    queue_item(CMD_ACK, 32'd100, 24'd10, 24'd5, 24'd20, 1'b1, 4'd0);
    queue_item(CMD_ACK, 32'd5000, 24'd10, 24'd5, 24'd20, 1'b0, 4'd3);
    queue_item(CMD_ACK, 32'd4000, 24'd10, 24'd5, 24'd20, 1'b1, 4'd7);
    queue_item(CMD_ACK, 32'd1, '1, '1, '1, 1'b1, 4'hF);
    queue_item(CMD_SPARE, 32'd3000, 24'd0, 24'd0, 24'd0, 1'b1, 4'd0);
    queue_item(CMD_NAK, '1, 24'd1, 24'd1, 24'd1, 1'b0, 4'hF);
    queue_item(CMD_QUERY, 32'h8000_0000, 24'h800000, 24'h7FFFFF, 24'h800000, 1'b1, 4'd8);
    wait_drained();

    // zero mtu collapses the window and both budgets
    write_reg(CFG_MTU, '0);
    wait_drained();
    queue_item(CMD_NAK, 32'd10, 24'd10, 24'd10, 24'd10, 1'b1, 4'd0);
    queue_item(CMD_ACK, 32'd0, 24'd10, 24'd10, 24'd10, 1'b1, 4'd0);
    queue_item(CMD_ACK, 32'd5, 24'd10, 24'd10, 24'd10, 1'b0, 4'd0);
    queue_item(CMD_SPARE, 32'd5, 24'd10, 24'd10, 24'd10, 1'b1, 4'd0);
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_MTU, 32'd64);
          write_reg(CFG_THRESH, 32'd0);
          write_reg(CFG_BASE, 32'd0);
        end
        1: begin
          write_reg(CFG_MTU, 32'd9000);
          write_reg(CFG_THRESH, '1);
          write_reg(CFG_BASE, 32'd1000000);
        end
        2: begin
          write_reg(CFG_MTU, 32'h3FFF);
          write_reg(CFG_THRESH, 32'd1);
          write_reg(CFG_BASE, 32'hFFFFF);
        end
        4: begin
          write_reg(CFG_MTU, 32'd1400);
          write_reg(CFG_THRESH, 32'd65536);
          write_reg(CFG_BASE, 32'd1000);
        end
        default: begin
          write_reg(CFG_MTU, $urandom_range(64, 9000));
          write_reg(CFG_THRESH, $urandom);
          write_reg(CFG_BASE, $urandom_range(0, 1000000));
        end
      endcase
      case (ph / 2)
        0: begin
          send_idle_pct = 25;
          recv_idle_pct = 68;
        end
        1: begin
          send_idle_pct = 68;
          recv_idle_pct = 25;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      wait_drained();

      // mostly acks so the window climbs out of slow start between naks
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        pick = $urandom_range(99);
        if (pick < 60)      cmd = CMD_ACK;
        else if (pick < 66) cmd = CMD_NAK;
        else if (pick < 88) cmd = CMD_QUERY;
        else                cmd = CMD_SPARE;
        case ($urandom_range(7))
          0: inflight = '0;
          1: inflight = '1;
          2, 3: inflight = $urandom;
          default: inflight = $urandom_range(0, 150000);
        endcase
        queue_item(cmd, inflight, rtt_sample(), rtt_sample(), rtt_sample(),
                   ($urandom_range(3) != 0), 4'($urandom_range(15)));
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    failures = mismatches + expected_results.size();
    if (failures == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
